/* rtl/plm_pkg.sv */
package plm_pkg;

    localparam int INDEX_W   = 4;
    localparam int CMD_W     = 2;
    localparam int SCAN_W    = 16;
    localparam int SCAN_IDX_W = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIRST  = 2'd2,
        CMD_NEXT   = 2'd3
    } plm_op_t;

    typedef struct packed {
        logic capture;
        logic search_step;
        logic add_commit;
        logic add_link;
        logic del_commit;
        logic first_result;
        logic next_result;
        logic null_result;
    } plm_cmd_t;

    typedef struct packed {
        logic found;
        logic last_chunk;
        logic tail_valid;
        logic entry_hit;
        logic out_free;
    } plm_stat_t;

endpackage

/* rtl/plm_ctrl.sv */
module plm_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [plm_pkg::CMD_W-1:0]   command,
    output logic                        in_ready,
    output plm_pkg::plm_cmd_t           cmd,
    input  plm_pkg::plm_stat_t          stat
);
    import plm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_SEARCH,
        ST_LINK
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    plm_op_t op_reg;
    plm_op_t op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    op_next     = plm_op_t'(command);
                    state_next  = (plm_op_t'(command) == CMD_ADD) ? ST_SEARCH : ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (stat.out_free)
                begin
                    case (op_reg)
                        CMD_DELETE:
                        begin
                            cmd.del_commit  = stat.entry_hit;
                            cmd.null_result = !stat.entry_hit;
                        end
                        CMD_FIRST:
                        begin
                            cmd.first_result = 1'b1;
                        end
                        CMD_NEXT:
                        begin
                            cmd.next_result = stat.entry_hit;
                            cmd.null_result = !stat.entry_hit;
                        end
                        default:
                        begin
                            cmd.null_result = 1'b1;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_SEARCH:
            begin
                if (stat.found)
                begin
                    if (stat.out_free)
                    begin
                        cmd.add_commit = 1'b1;
                        state_next     = stat.tail_valid ? ST_LINK : ST_IDLE;
                    end
                end
                else if (stat.last_chunk)
                begin
                    if (stat.out_free)
                    begin
                        cmd.null_result = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            ST_LINK:
            begin
                cmd.add_link = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= CMD_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

/* rtl/plm_dpath.sv */
module plm_dpath #(
    parameter int POOL_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [plm_pkg::INDEX_W-1:0]   entry_index,
    input  logic                          entry_present,
    input  logic                          out_ready,
    input  plm_pkg::plm_cmd_t             cmd,
    output plm_pkg::plm_stat_t            stat,
    output logic                          out_valid,
    output logic [plm_pkg::INDEX_W-1:0]   result_index,
    output logic                          result_valid,
    output logic                          list_empty
);
    import plm_pkg::*;

    localparam int IDX_W  = $clog2(POOL_SIZE + 1);
    localparam int SLOT_W = $clog2(POOL_SIZE);
    localparam int NCHUNK = (POOL_SIZE + SCAN_W - 1) / SCAN_W;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int NROW   = 1 << CW;
    localparam logic [IDX_W-1:0] NIL = IDX_W'(POOL_SIZE);

    logic [IDX_W-1:0]     next_mem [POOL_SIZE];
    logic [IDX_W-1:0]     prev_mem [POOL_SIZE];
    logic [IDX_W-1:0]     nx_rd_reg;
    logic [IDX_W-1:0]     pv_rd_reg;

    logic [POOL_SIZE-1:0] active_reg;
    logic [POOL_SIZE-1:0] active_next;
    logic [IDX_W-1:0]     head_reg;
    logic [IDX_W-1:0]     head_next;
    logic [IDX_W-1:0]     tail_reg;
    logic [IDX_W-1:0]     tail_next;
    logic [IDX_W-1:0]     old_tail_reg;
    logic [IDX_W-1:0]     old_tail_next;
    logic [SLOT_W-1:0]    entry_reg;
    logic [SLOT_W-1:0]    entry_next;
    logic                 entry_ok_reg;
    logic                 entry_ok_next;
    logic [CW-1:0]        chunk_reg;
    logic [CW-1:0]        chunk_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [INDEX_W-1:0]   res_index_reg;
    logic [INDEX_W-1:0]   res_index_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    logic                 empty_reg;
    logic                 empty_next;

    logic                 entry_ok;
    logic [SLOT_W-1:0]    rd_addr;
    logic [SCAN_W-1:0]    scan_rows [NROW];
    logic [SCAN_W-1:0]    row;
    logic [SCAN_IDX_W-1:0] pos;
    logic                 found;
    logic [IDX_W-1:0]     slot;
    logic [IDX_W-1:0]     prev_slot;
    logic [IDX_W-1:0]     after;
    logic [IDX_W-1:0]     res_link;
    logic                 load;

    logic                 nx_we;
    logic [SLOT_W-1:0]    nx_waddr;
    logic [IDX_W-1:0]     nx_wdata;
    logic                 pv_we;
    logic [SLOT_W-1:0]    pv_waddr;
    logic [IDX_W-1:0]     pv_wdata;

    assign entry_ok  = entry_present && (int'(entry_index) < POOL_SIZE);
    assign rd_addr   = SLOT_W'(entry_index);
    assign prev_slot = pv_rd_reg;
    assign after     = nx_rd_reg;

    always_comb
    begin
        int flat;
        for (int r = 0; r < NROW; r++)
        begin
            for (int b = 0; b < SCAN_W; b++)
            begin
                flat = r * SCAN_W + b;
                scan_rows[r][b] = (flat < POOL_SIZE) ? active_reg[flat] : 1'b1;
            end
        end
    end

    assign row   = scan_rows[chunk_reg];
    assign found = ~&row;

    always_comb
    begin
        pos = '0;
        for (int b = SCAN_W - 1; b >= 0; b--)
        begin
            if (!row[b])
            begin
                pos = SCAN_IDX_W'(b);
            end
        end
    end

    assign slot = IDX_W'({chunk_reg, pos});

    assign stat.found      = found;
    assign stat.last_chunk = (chunk_reg == CW'(NCHUNK - 1));
    assign stat.tail_valid = (tail_reg != NIL);
    assign stat.entry_hit  = entry_ok_reg && active_reg[entry_reg];
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        active_next   = active_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        old_tail_next = old_tail_reg;
        entry_next    = entry_reg;
        entry_ok_next = entry_ok_reg;
        chunk_next    = chunk_reg;
        nx_we         = 1'b0;
        nx_waddr      = '0;
        nx_wdata      = NIL;
        pv_we         = 1'b0;
        pv_waddr      = '0;
        pv_wdata      = NIL;

        if (cmd.capture)
        begin
            entry_next    = rd_addr;
            entry_ok_next = entry_ok;
            chunk_next    = '0;
        end
        if (cmd.search_step)
        begin
            chunk_next = chunk_reg + 1'b1;
        end
        if (cmd.add_commit)
        begin
            active_next[SLOT_W'(slot)] = 1'b1;
            tail_next     = slot;
            old_tail_next = tail_reg;
            if (head_reg == NIL)
            begin
                head_next = slot;
            end
            nx_we    = 1'b1;
            nx_waddr = SLOT_W'(slot);
            nx_wdata = NIL;
            pv_we    = 1'b1;
            pv_waddr = SLOT_W'(slot);
            pv_wdata = tail_reg;
        end
        if (cmd.add_link)
        begin
            nx_we    = 1'b1;
            nx_waddr = SLOT_W'(old_tail_reg);
            nx_wdata = tail_reg;
        end
        if (cmd.del_commit)
        begin
            active_next[entry_reg] = 1'b0;
            if (prev_slot == NIL)
            begin
                head_next = after;
            end
            else
            begin
                nx_we    = 1'b1;
                nx_waddr = SLOT_W'(prev_slot);
                nx_wdata = after;
            end
            if (tail_reg == IDX_W'(entry_reg))
            begin
                tail_next = prev_slot;
            end
            if (after != NIL)
            begin
                pv_we    = 1'b1;
                pv_waddr = SLOT_W'(after);
                pv_wdata = prev_slot;
            end
        end
    end

    always_comb
    begin
        res_link = NIL;
        if (cmd.add_commit)
        begin
            res_link = slot;
        end
        else if (cmd.del_commit)
        begin
            res_link = after;
        end
        else if (cmd.first_result)
        begin
            res_link = head_reg;
        end
        else if (cmd.next_result)
        begin
            res_link = nx_rd_reg;
        end
    end

    assign load = cmd.add_commit | cmd.del_commit | cmd.first_result
                | cmd.next_result | cmd.null_result;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_index_next = res_index_reg;
        res_valid_next = res_valid_reg;
        empty_next     = empty_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            res_valid_next = (res_link != NIL);
            res_index_next = (res_link != NIL) ? INDEX_W'(res_link) : '0;
            empty_next     = (head_next == NIL);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            entry_ok_reg  <= 1'b0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            entry_ok_reg  <= entry_ok_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        old_tail_reg  <= old_tail_next;
        entry_reg     <= entry_next;
        res_index_reg <= res_index_next;
        res_valid_reg <= res_valid_next;
        empty_reg     <= empty_next;
    end

    always_ff @(posedge clk)
    begin
        if (nx_we)
        begin
            next_mem[nx_waddr] <= nx_wdata;
        end
        if (pv_we)
        begin
            prev_mem[pv_waddr] <= pv_wdata;
        end
        if (cmd.capture)
        begin
            nx_rd_reg <= next_mem[rd_addr];
            pv_rd_reg <= prev_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_index = res_index_reg;
    assign result_valid = res_valid_reg;
    assign list_empty   = empty_reg;

endmodule

/* rtl/pool_linked_list_manager_top.sv */
// Doubly linked list over a fixed pool of POOL_SIZE slots. Each request gives exactly one
// result: add returns the lowest free slot appended at the tail (null when the pool is full),
// delete unlinks an active slot and returns its follower, first returns the head and next the
// successor of an active slot; list_empty reports the list after the request. One request is
// in work at a time, and a new request is taken while the previous result still waits on the
// output register. Delete, first and next pass through a resolve state, needed by the registered
// read of the link memories, and give their result once the output register is free. Add scans
// the free slots one 16-slot group at a time (at most ceil(POOL_SIZE/16) groups), then enters a
// link state for the old tail when the list was not empty. Link memories need no clearing pass.
module pool_linked_list_manager_top #(
    parameter int POOL_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [plm_pkg::CMD_W-1:0]     command,
    input  logic [plm_pkg::INDEX_W-1:0]   entry_index,
    input  logic                          entry_present,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [plm_pkg::INDEX_W-1:0]   result_index,
    output logic                          result_valid,
    output logic                          list_empty
);
    import plm_pkg::*;

    plm_cmd_t  cmd;
    plm_stat_t stat;

    plm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    plm_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_index   (entry_index),
        .entry_present (entry_present),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .result_index  (result_index),
        .result_valid  (result_valid),
        .list_empty    (list_empty)
    );

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while another is in work");

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !result_valid) |-> (result_index == '0))
        else $error("null result carries a nonzero index");

    a_valid_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_valid) |-> !list_empty)
        else $error("valid result reported with an empty list");

    a_single_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.add_commit, cmd.del_commit, cmd.first_result,
                  cmd.next_result, cmd.null_result}))
        else $error("more than one result source in one cycle");
`endif

endmodule

/* tb/tb_pool_linked_list_manager_top.sv */
module tb_pool_linked_list_manager_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plm_pkg::*;

    localparam int POOL = 16;
    localparam logic [4:0] NO_SLOT = 5'(POOL);
    localparam int RANDOM_REQUESTS = 1670;

    typedef struct packed {
        plm_op_t             op;
        logic [INDEX_W-1:0]  index;
        logic                present;
    } list_request_t;

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic                valid;
        logic                empty;
    } list_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    plm_op_t             command = CMD_ADD;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic                entry_present = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [INDEX_W-1:0]  result_index;
    logic                result_valid;
    logic                list_empty;

    list_request_t  request_queue[$];
    list_result_t   pending_results[$];
    list_request_t  on_bus;
    int             accepted_count = 0;
    int             total_requests = 0;
    int             errors = 0;

    logic           slot_busy [POOL];
    logic [4:0]     link_fwd  [POOL];
    logic [4:0]     link_back [POOL];
    logic [4:0]     head_slot = NO_SLOT;
    logic [4:0]     tail_slot = NO_SLOT;

    pool_linked_list_manager_top #(
        .POOL_SIZE(POOL)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .entry_index  (entry_index),
        .entry_present(entry_present),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_index (result_index),
        .result_valid (result_valid),
        .list_empty   (list_empty)
    );

    always #5 clk = ~clk;

    function automatic int sender_idle_pct();
        if (accepted_count < total_requests / 3)
            return 20;
        else if (accepted_count < 2 * total_requests / 3)
            return 56;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (accepted_count < total_requests / 3)
            return 56;
        else if (accepted_count < 2 * total_requests / 3)
            return 20;
        return 0;
    endfunction

    function automatic void apply_list_op(input list_request_t req);
        logic [4:0]    found;
        logic [4:0]    before_slot;
        logic [4:0]    after_slot;
        logic [4:0]    answer;
        list_result_t  res;
        answer = NO_SLOT;
        case (req.op)
            CMD_ADD:
            begin
                found = NO_SLOT;
                for (int i = POOL - 1; i >= 0; i--)
                begin
                    if (!slot_busy[i])
                        found = 5'(i);
                end
                if (found != NO_SLOT)
                begin
                    if (tail_slot != NO_SLOT)
                        link_fwd[tail_slot[3:0]] = found;
                    slot_busy[found[3:0]] = 1'b1;
                    link_back[found[3:0]] = tail_slot;
                    link_fwd[found[3:0]] = NO_SLOT;
                    tail_slot = found;
                    if (head_slot == NO_SLOT)
                        head_slot = found;
                    answer = found;
                end
            end
            CMD_DELETE:
            begin
                if (req.present && slot_busy[req.index])
                begin
                    before_slot = link_back[req.index];
                    after_slot = link_fwd[req.index];
                    if (before_slot == NO_SLOT)
                        head_slot = after_slot;
                    else
                        link_fwd[before_slot[3:0]] = after_slot;
                    if (tail_slot == {1'b0, req.index})
                        tail_slot = before_slot;
                    if (after_slot != NO_SLOT)
                        link_back[after_slot[3:0]] = before_slot;
                    slot_busy[req.index] = 1'b0;
                    link_fwd[req.index] = NO_SLOT;
                    link_back[req.index] = NO_SLOT;
                    answer = after_slot;
                end
            end
            CMD_FIRST:
                answer = head_slot;
            default:
            begin
                if (req.present && slot_busy[req.index])
                    answer = link_fwd[req.index];
            end
        endcase
        res.valid = (answer != NO_SLOT);
        res.index = res.valid ? answer[3:0] : '0;
        res.empty = (head_slot == NO_SLOT);
        pending_results.push_back(res);
    endfunction

    function automatic void push_request(input plm_op_t op, input logic [INDEX_W-1:0] idx,
                                         input logic present);
        list_request_t req;
        req.op = op;
        req.index = idx;
        req.present = present;
        request_queue.push_back(req);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= CMD_ADD;
            entry_index <= '0;
            entry_present <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_list_op(on_bus);
                accepted_count <= accepted_count + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    on_bus = request_queue.pop_front();
                    in_valid <= 1'b1;
                    command <= on_bus.op;
                    entry_index <= on_bus.index;
                    entry_present <= on_bus.present;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no request pending: result_index %0d", result_index);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result_index !== want.index)
                    begin
                        $error("result_index: expected %0d, got %0d", want.index, result_index);
                        errors++;
                    end
                    if (result_valid !== want.valid)
                    begin
                        $error("result_valid: expected %0d, got %0d", want.valid, result_valid);
                        errors++;
                    end
                    if (list_empty !== want.empty)
                    begin
                        $error("list_empty: expected %0d, got %0d", want.empty, list_empty);
                        errors++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    initial
    begin
        logic              grow;
        int                roll;
        int                hi;
        plm_op_t           op;
        logic [INDEX_W-1:0] idx;
        logic              present;

        for (int i = 0; i < POOL; i++)
        begin
            slot_busy[i] = 1'b0;
            link_fwd[i] = NO_SLOT;
            link_back[i] = NO_SLOT;
        end

        push_request(CMD_FIRST, 4'd0, 1'b0);
        push_request(CMD_NEXT, 4'd15, 1'b1);
        push_request(CMD_DELETE, 4'd0, 1'b1);
        for (int i = 0; i < POOL; i++)
            push_request(CMD_ADD, 4'($urandom_range(15)), 1'($urandom_range(1)));
        push_request(CMD_ADD, 4'd15, 1'b1);
        push_request(CMD_NEXT, 4'd15, 1'b1);
        push_request(CMD_NEXT, 4'd3, 1'b0);
        push_request(CMD_DELETE, 4'd5, 1'b0);
        push_request(CMD_DELETE, 4'd0, 1'b1);
        push_request(CMD_DELETE, 4'd15, 1'b1);
        push_request(CMD_DELETE, 4'd7, 1'b1);
        push_request(CMD_FIRST, 4'd15, 1'b1);
        push_request(CMD_ADD, 4'd0, 1'b0);
        push_request(CMD_NEXT, 4'd14, 1'b1);

        grow = 1'b1;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 60 == 0)
                grow = ~grow;
            roll = $urandom_range(99);
            hi = ($urandom_range(2) == 0) ? 15 : (($urandom_range(1) == 0) ? 7 : 3);
            idx = 4'($urandom_range(hi));
            present = ($urandom_range(9) != 0);
            if (roll < (grow ? 50 : 15))
                op = CMD_ADD;
            else if (roll < (grow ? 70 : 65))
                op = CMD_DELETE;
            else if (roll < (grow ? 78 : 75))
                op = CMD_FIRST;
            else
                op = CMD_NEXT;
            push_request(op, idx, present);
        end
        total_requests = request_queue.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("pool_linked_list_manager_top regression: pass");
        else
            $display("pool_linked_list_manager_top regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("pool_linked_list_manager_top regression: fail");
        $finish;
    end

endmodule

/* pool_linked_list_manager_top.f */
rtl/plm_pkg.sv
rtl/plm_ctrl.sv
rtl/plm_dpath.sv
rtl/pool_linked_list_manager_top.sv
tb/tb_pool_linked_list_manager_top.sv
